FILE: design/lrupr_pkg.sv
// Shared constants, types and helpers of the LRU page replacement unit.
`timescale 1ns / 1ps
package lrupr_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int PAGE_BITS   = 16;
    localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
    localparam int FILL_W      = FRAME_IDX_W + 1;
    localparam int RANK_W      = FRAME_IDX_W;
    localparam int CFG_W       = 5;
    localparam int COUNT_W     = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } lrupr_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } lrupr_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } lrupr_status_t;

    // Clamp the programmed frame count into 1..MAX_FRAMES.
    function automatic logic [FILL_W-1:0] eff_limit(input logic [CFG_W-1:0] cfg);
        logic [FILL_W-1:0] lim;
        if (cfg == '0) begin
            lim = FILL_W'(1);
        end else if (int'(cfg) > MAX_FRAMES) begin
            lim = FILL_W'(MAX_FRAMES);
        end else begin
            lim = FILL_W'(cfg);
        end
        return lim;
    endfunction

endpackage

FILE: design/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit.
//
//  channel | ports                                  | transfer
//  --------+----------------------------------------+-------------------------
//  in      | s_valid, s_ready, s_page               | s_valid & s_ready
//  out     | m_valid, m_ready, m_hit, m_frame_index,| m_valid & m_ready
//          | m_evicted_*, m_fault_count             |
//  config  | cfg_we, cfg_wdata                      | cfg_we
//
// Each word is accepted, then the frame page memory is scanned over all
// MAX_FRAMES frames one frame a cycle (hit search and LRU victim in the same
// pass), then ranks, memory and the result register are updated.
// The update stalls while the result register still holds an untaken word.
// Synchronous active-low reset clears valid bits, ranks, counts and sets
// the frame count register to 16; the page memory is not cleared.
`timescale 1ns / 1ps
module lru_page_replacement_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]       s_page,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [lrupr_pkg::FRAME_IDX_W-1:0]     m_frame_index,
    output logic                                  m_evicted_valid,
    output logic [lrupr_pkg::PAGE_BITS-1:0]       m_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]         m_fault_count
);

    lrupr_pkg::lrupr_cmd_t    cmd;
    lrupr_pkg::lrupr_status_t status;

    lrupr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lrupr_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_page          (s_page),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_frame_index   (m_frame_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_fault_count   (m_fault_count)
    );

endmodule

FILE: design/lrupr_ctrl.sv
// Sequencer of the LRU page replacement unit: accept, frame scan, update.
`timescale 1ns / 1ps
module lrupr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lrupr_pkg::lrupr_status_t status,
    output lrupr_pkg::lrupr_cmd_t    cmd
);

    lrupr_pkg::lrupr_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lrupr_pkg::ST_IDLE: begin
                if (s_valid) state_next = lrupr_pkg::ST_SCAN;
            end
            lrupr_pkg::ST_SCAN: begin
                if (status.scan_last) state_next = lrupr_pkg::ST_UPDATE;
            end
            lrupr_pkg::ST_UPDATE: begin
                // hold until the result register can take the word
                if (status.out_free) state_next = lrupr_pkg::ST_IDLE;
            end
            default: state_next = lrupr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrupr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready    = (state_reg == lrupr_pkg::ST_IDLE);
    assign cmd.load   = (state_reg == lrupr_pkg::ST_IDLE) && s_valid;
    assign cmd.scan   = (state_reg == lrupr_pkg::ST_SCAN);
    assign cmd.commit = (state_reg == lrupr_pkg::ST_UPDATE) && status.out_free;

endmodule

FILE: design/lrupr_dp.sv
// Datapath: frame page memory, valid bits, recency ranks, counters, result register.
`timescale 1ns / 1ps
module lrupr_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lrupr_pkg::lrupr_cmd_t                 cmd,
    output lrupr_pkg::lrupr_status_t              status,
    input  logic                                  cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]       s_page,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [lrupr_pkg::FRAME_IDX_W-1:0]     m_frame_index,
    output logic                                  m_evicted_valid,
    output logic [lrupr_pkg::PAGE_BITS-1:0]       m_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]         m_fault_count
);

    localparam int NF = lrupr_pkg::MAX_FRAMES;
    localparam int IW = lrupr_pkg::FRAME_IDX_W;
    localparam int FW = lrupr_pkg::FILL_W;
    localparam int RW = lrupr_pkg::RANK_W;
    localparam int PW = lrupr_pkg::PAGE_BITS;
    localparam int CW = lrupr_pkg::COUNT_W;

    logic [PW-1:0] page_mem [NF];
    logic [PW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;

    logic [lrupr_pkg::CFG_W-1:0] cfg_reg;
    logic [PW-1:0] page_reg;
    logic [FW-1:0] limit_reg;
    logic [IW-1:0] idx_reg;

    logic          hit_found_reg;
    logic [IW-1:0] hit_frame_reg;
    logic [RW-1:0] hit_rank_reg;
    logic          vic_found_reg;
    logic [IW-1:0] vic_frame_reg;
    logic [RW-1:0] vic_rank_reg;
    logic [PW-1:0] vic_page_reg;

    logic [NF-1:0] valid_reg;
    logic [RW-1:0] rank_reg  [NF];
    logic [RW-1:0] rank_next [NF];
    logic [FW-1:0] filled_reg;
    logic [CW-1:0] faults_reg, faults_next;

    logic          m_valid_reg;
    logic          m_hit_reg;
    logic [IW-1:0] m_frame_reg;
    logic          m_ev_valid_reg;
    logic [PW-1:0] m_ev_page_reg;
    logic [CW-1:0] m_count_reg;

    // scan compare of the frame whose page sits in rd_data_reg
    logic          cur_valid;
    logic [RW-1:0] cur_rank;
    logic          cur_match;
    logic          cur_better;

    // update decision
    logic          fill;
    logic [IW-1:0] tgt;
    logic [RW-1:0] old_rank;

    assign status.scan_last = (idx_reg == IW'(NF - 1));
    assign status.out_free  = !m_valid_reg || m_ready;

    // Read one frame ahead of the compare.
    assign rd_addr = cmd.load ? '0 : idx_reg + IW'(1);

    always_ff @(posedge aclk) begin
        rd_data_reg <= page_mem[rd_addr];
        if (cmd.commit && !hit_found_reg) begin
            page_mem[tgt] <= page_reg;
        end
    end

    assign cur_valid  = valid_reg[idx_reg];
    assign cur_rank   = rank_reg[idx_reg];
    assign cur_match  = cur_valid && (rd_data_reg == page_reg);
    assign cur_better = cur_valid && ({1'b0, idx_reg} < limit_reg)
                        && (!vic_found_reg || cur_rank > vic_rank_reg);

    assign fill     = !hit_found_reg && (filled_reg < limit_reg);
    assign tgt      = hit_found_reg ? hit_frame_reg
                    : (fill ? filled_reg[IW-1:0] : vic_frame_reg);
    assign old_rank = hit_found_reg ? hit_rank_reg : vic_rank_reg;

    always_comb begin
        for (int i = 0; i < NF; i++) begin
            rank_next[i] = rank_reg[i];
            if (IW'(i) == tgt) begin
                rank_next[i] = '0;
            end else if (valid_reg[i] && (fill || rank_reg[i] < old_rank)) begin
                rank_next[i] = rank_reg[i] + RW'(1);
            end
        end
    end

    always_comb begin
        faults_next = faults_reg;
        if (!hit_found_reg && faults_reg != '1) faults_next = faults_reg + CW'(1);
    end

    // Per-item scan registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            page_reg      <= s_page;
            limit_reg     <= lrupr_pkg::eff_limit(cfg_reg);
            idx_reg       <= '0;
            hit_found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
        end else if (cmd.scan) begin
            idx_reg <= idx_reg + IW'(1);
            if (cur_match && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
                hit_frame_reg <= idx_reg;
                hit_rank_reg  <= cur_rank;
            end
            if (cur_better) begin
                vic_found_reg <= 1'b1;
                vic_frame_reg <= idx_reg;
                vic_rank_reg  <= cur_rank;
                vic_page_reg  <= rd_data_reg;
            end
        end
    end

    // Replacement state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg    <= lrupr_pkg::CFG_RESET;
            valid_reg  <= '0;
            filled_reg <= '0;
            faults_reg <= '0;
            for (int i = 0; i < NF; i++) rank_reg[i] <= '0;
        end else begin
            if (cfg_we) cfg_reg <= cfg_wdata;
            if (cmd.commit) begin
                rank_reg   <= rank_next;
                faults_reg <= faults_next;
                if (fill) begin
                    valid_reg[tgt] <= 1'b1;
                    filled_reg     <= filled_reg + FW'(1);
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_hit_reg      <= hit_found_reg;
            m_frame_reg    <= tgt;
            m_ev_valid_reg <= !hit_found_reg && !fill;
            m_ev_page_reg  <= (!hit_found_reg && !fill) ? vic_page_reg : '0;
            m_count_reg    <= faults_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_frame_index   = m_frame_reg;
    assign m_evicted_valid = m_ev_valid_reg;
    assign m_evicted_page  = m_ev_page_reg;
    assign m_fault_count   = m_count_reg;

endmodule

FILE: design/lrupr_checker.sv
// Port-level checks of the LRU page replacement unit, bound to the top level.
`timescale 1ns / 1ps
module lrupr_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic                                  m_hit,
    input logic                                  m_evicted_valid,
    input logic [lrupr_pkg::PAGE_BITS-1:0]       m_evicted_page,
    input logic [lrupr_pkg::COUNT_W-1:0]         m_fault_count
);

    // one word at a time: no second accept right after the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fault_count))
        else $error("result word dropped or changed while stalled");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_evicted_valid && m_evicted_page == '0)
        else $error("hit reported an eviction");

    a_fault_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_fault_count != '0)
        else $error("fault reported with zero fault count");

    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> m_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_replacement_unit lrupr_checker u_lrupr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_hit           (m_hit),
    .m_evicted_valid (m_evicted_valid),
    .m_evicted_page  (m_evicted_page),
    .m_fault_count   (m_fault_count)
);
